// ----- rtl/lkr_pkg.sv -----
// Package: types, constants and command codes shared by the repeat-finder modules.
`timescale 1ns / 1ps
package lkr_pkg;

    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int SUM_W   = LEN_W + 1;
    localparam int RANK_W  = ADDR_W;
    localparam int RANK2_W = ADDR_W + 1;
    localparam int K_W     = 11;
    localparam int OUT_W   = 12;
    localparam int SYM_W   = 8;
    localparam logic [K_W-1:0] K_RESET = K_W'(2);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } sym_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] longest_len;
        logic                    too_long;
    } res_t;

    typedef struct packed {
        logic [RANK_W-1:0]  r1;
        logic [RANK2_W-1:0] r2;
        logic [ADDR_W-1:0]  idx;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int KEY_W   = RANK_W + RANK2_W;

    typedef enum logic [4:0] {
        S_IDLE, S_START,
        S_BLD0, S_BLD1, S_BLD2,
        S_SRT_INIT, S_SRT0, S_SRT1, S_SRT2, S_SRT3,
        S_RNK_INIT, S_RNK0, S_RNK1, S_CHK,
        S_LCP_INIT, S_LCP0, S_LCP1, S_LCP2,
        S_CMP0, S_CMP1, S_CMP2,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_START,
        OP_BLD_I, OP_BLD_IH, OP_BLD_WR,
        OP_SRT_INIT, OP_SRT_FETCH, OP_SRT_TAKE, OP_SRT_SHIFT, OP_SRT_PLACE,
        OP_RNK_INIT, OP_RNK_FETCH, OP_RNK_WR, OP_DOUBLE,
        OP_LCP_INIT, OP_LCP_A, OP_LCP_B, OP_LCP_TAKE,
        OP_CMP_A, OP_CMP_B, OP_CMP_INC, OP_LCP_NEXT,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic k_fits;
        logic last_i;
        logic n_one;
        logic j_one;
        logic v_less;
        logic sort_done;
        logic in_range;
        logic eq;
        logic lcp_last;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/lkr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/lkr_ctrl.sv -----
// Controller state machine: sequences load, doubling rounds, ranking and the LCP scan.
`timescale 1ns / 1ps
module lkr_ctrl import lkr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sym_valid,
    input  logic    sym_last,
    output logic    sym_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        sym_stall  = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (sym_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (sym_last)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                cmd.op     = OP_START;
                state_next = status.k_fits ? S_BLD0 : S_DONE;
            end
            S_BLD0:
            begin
                cmd.op     = OP_BLD_I;
                state_next = S_BLD1;
            end
            S_BLD1:
            begin
                cmd.op     = OP_BLD_IH;
                state_next = S_BLD2;
            end
            S_BLD2:
            begin
                cmd.op     = OP_BLD_WR;
                state_next = status.last_i ? S_SRT_INIT : S_BLD0;
            end
            S_SRT_INIT:
            begin
                cmd.op     = OP_SRT_INIT;
                state_next = status.n_one ? S_RNK_INIT : S_SRT0;
            end
            S_SRT0:
            begin
                cmd.op     = OP_SRT_FETCH;
                state_next = S_SRT1;
            end
            S_SRT1:
            begin
                cmd.op     = OP_SRT_TAKE;
                state_next = S_SRT2;
            end
            S_SRT2:
            begin
                if (status.v_less)
                begin
                    cmd.op     = OP_SRT_SHIFT;
                    state_next = status.j_one ? S_SRT3 : S_SRT2;
                end
                else
                begin
                    cmd.op     = OP_SRT_PLACE;
                    state_next = status.last_i ? S_RNK_INIT : S_SRT0;
                end
            end
            S_SRT3:
            begin
                cmd.op     = OP_SRT_PLACE;
                state_next = status.last_i ? S_RNK_INIT : S_SRT0;
            end
            S_RNK_INIT:
            begin
                cmd.op     = OP_RNK_INIT;
                state_next = S_RNK0;
            end
            S_RNK0:
            begin
                cmd.op     = OP_RNK_FETCH;
                state_next = S_RNK1;
            end
            S_RNK1:
            begin
                cmd.op     = OP_RNK_WR;
                state_next = status.last_i ? S_CHK : S_RNK0;
            end
            S_CHK:
            begin
                if (status.sort_done)
                begin
                    state_next = S_LCP_INIT;
                end
                else
                begin
                    cmd.op     = OP_DOUBLE;
                    state_next = S_BLD0;
                end
            end
            S_LCP_INIT:
            begin
                cmd.op     = OP_LCP_INIT;
                state_next = S_LCP0;
            end
            S_LCP0:
            begin
                cmd.op     = OP_LCP_A;
                state_next = S_LCP1;
            end
            S_LCP1:
            begin
                cmd.op     = OP_LCP_B;
                state_next = S_LCP2;
            end
            S_LCP2:
            begin
                cmd.op     = OP_LCP_TAKE;
                state_next = S_CMP0;
            end
            S_CMP0:
            begin
                if (status.in_range)
                begin
                    cmd.op     = OP_CMP_A;
                    state_next = S_CMP1;
                end
                else
                begin
                    cmd.op     = OP_LCP_NEXT;
                    state_next = status.lcp_last ? S_DONE : S_LCP0;
                end
            end
            S_CMP1:
            begin
                cmd.op     = OP_CMP_B;
                state_next = S_CMP2;
            end
            S_CMP2:
            begin
                if (status.eq)
                begin
                    cmd.op     = OP_CMP_INC;
                    state_next = S_CMP0;
                end
                else
                begin
                    cmd.op     = OP_LCP_NEXT;
                    state_next = status.lcp_last ? S_DONE : S_LCP0;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lkr_dp.sv -----
// Datapath: text, rank and suffix-entry memories, counters and the result register.
`timescale 1ns / 1ps
module lkr_dp import lkr_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  cmd_t           cmd,
    output status_t        status,
    input  sym_t           sym_item,
    input  logic           cfg_we,
    input  logic [K_W-1:0] cfg_data,
    output logic           res_valid,
    input  logic           res_stall,
    output res_t           res_item
);

    logic [LEN_W-1:0]   len_reg, n_reg, k_reg, h_reg, i_reg, c_reg, best_reg;
    logic [ADDR_W-1:0]  j_reg, a_reg, b_reg, top_reg;
    logic [RANK_W-1:0]  r1a_reg;
    logic [SYM_W-1:0]   ta_reg;
    logic [KEY_W-1:0]   prev_reg;
    logic [K_W-1:0]     min_rep_reg;
    logic               ovf_reg, ovf_res_reg, res_valid_reg;
    entry_t             v_reg;
    res_t               res_item_reg;

    logic               text_we, rank_we, ent_we;
    logic [ADDR_W-1:0]  text_waddr, text_raddr, rank_waddr, rank_raddr, ent_waddr, ent_raddr;
    logic [SYM_W-1:0]   text_rdata;
    logic [RANK_W-1:0]  rank_wdata, rank_rdata;
    logic [ENTRY_W-1:0] ent_rdata_raw;
    entry_t             ent_rdata, ent_wdata;

    logic [LEN_W-1:0]   keff;
    logic [SUM_W-1:0]   ih_sum, ik_sum, ac_sum, bc_sum;
    logic [ADDR_W-1:0]  top_new;

    assign ent_rdata = entry_t'(ent_rdata_raw);
    assign keff      = (min_rep_reg == '0) ? LEN_W'(1) : LEN_W'(min_rep_reg);
    assign ih_sum    = SUM_W'(i_reg) + SUM_W'(h_reg);
    assign ik_sum    = SUM_W'(i_reg) + SUM_W'(k_reg);
    assign ac_sum    = SUM_W'(a_reg) + SUM_W'(c_reg);
    assign bc_sum    = SUM_W'(b_reg) + SUM_W'(c_reg);
    assign top_new   = ((i_reg != '0) && ({ent_rdata.r1, ent_rdata.r2} != prev_reg))
                       ? top_reg + ADDR_W'(1) : top_reg;

    lkr_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_text (
        .clk(clk), .we(text_we), .waddr(text_waddr), .wdata(sym_item.symbol),
        .raddr(text_raddr), .rdata(text_rdata)
    );

    lkr_ram #(.WIDTH(RANK_W), .DEPTH(MAX_LEN)) u_rank (
        .clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
        .raddr(rank_raddr), .rdata(rank_rdata)
    );

    lkr_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_LEN)) u_entry (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ENTRY_W'(ent_wdata)),
        .raddr(ent_raddr), .rdata(ent_rdata_raw)
    );

    always_comb
    begin
        status.k_fits    = (keff <= len_reg);
        status.last_i    = (i_reg == n_reg - LEN_W'(1));
        status.n_one     = (n_reg == LEN_W'(1));
        status.j_one     = (j_reg == ADDR_W'(1));
        status.v_less    = ({v_reg.r1, v_reg.r2} < {ent_rdata.r1, ent_rdata.r2});
        status.sort_done = ((LEN_W'(top_reg) + LEN_W'(1)) >= n_reg) || (h_reg >= n_reg);
        status.in_range  = (ac_sum < SUM_W'(n_reg)) && (bc_sum < SUM_W'(n_reg));
        status.eq        = (ta_reg == text_rdata);
        status.lcp_last  = (ik_sum >= SUM_W'(n_reg));
        status.out_free  = !res_valid_reg || !res_stall;
    end

    always_comb
    begin
        text_we    = 1'b0;
        text_waddr = len_reg[ADDR_W-1:0];
        text_raddr = ac_sum[ADDR_W-1:0];
        rank_we    = 1'b0;
        rank_waddr = len_reg[ADDR_W-1:0];
        rank_wdata = RANK_W'(sym_item.symbol);
        rank_raddr = i_reg[ADDR_W-1:0];
        ent_we     = 1'b0;
        ent_waddr  = i_reg[ADDR_W-1:0];
        ent_raddr  = i_reg[ADDR_W-1:0];
        ent_wdata  = v_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                text_we = (len_reg < LEN_W'(MAX_LEN));
                rank_we = (len_reg < LEN_W'(MAX_LEN));
            end
            OP_BLD_IH:
            begin
                rank_raddr = ih_sum[ADDR_W-1:0];
            end
            OP_BLD_WR:
            begin
                ent_we       = 1'b1;
                ent_wdata.r1 = r1a_reg;
                ent_wdata.r2 = (ih_sum < SUM_W'(n_reg))
                               ? RANK2_W'(rank_rdata) + RANK2_W'(1) : '0;
                ent_wdata.idx = i_reg[ADDR_W-1:0];
            end
            OP_SRT_TAKE:
            begin
                ent_raddr = i_reg[ADDR_W-1:0] - ADDR_W'(1);
            end
            OP_SRT_SHIFT:
            begin
                ent_we    = 1'b1;
                ent_waddr = j_reg;
                ent_wdata = ent_rdata;
                ent_raddr = j_reg - ADDR_W'(2);
            end
            OP_SRT_PLACE:
            begin
                ent_we    = 1'b1;
                ent_waddr = j_reg;
            end
            OP_RNK_WR:
            begin
                rank_we    = 1'b1;
                rank_waddr = ent_rdata.idx;
                rank_wdata = top_new;
            end
            OP_LCP_B:
            begin
                ent_raddr = ik_sum[ADDR_W-1:0] - ADDR_W'(1);
            end
            OP_CMP_B:
            begin
                text_raddr = bc_sum[ADDR_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            min_rep_reg   <= K_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_rep_reg <= cfg_data;
            end
            if (res_valid_reg && !res_stall && (cmd.op != OP_FINISH))
            begin
                res_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    if (len_reg < LEN_W'(MAX_LEN))
                    begin
                        len_reg <= len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                OP_START:
                begin
                    len_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                OP_FINISH:
                begin
                    res_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_START:
            begin
                n_reg       <= len_reg;
                k_reg       <= keff;
                ovf_res_reg <= ovf_reg;
                h_reg       <= LEN_W'(1);
                i_reg       <= '0;
                best_reg    <= '0;
            end
            OP_BLD_IH:
            begin
                r1a_reg <= rank_rdata;
            end
            OP_BLD_WR:
            begin
                i_reg <= i_reg + LEN_W'(1);
            end
            OP_SRT_INIT:
            begin
                i_reg <= LEN_W'(1);
            end
            OP_SRT_FETCH:
            begin
                j_reg <= i_reg[ADDR_W-1:0];
            end
            OP_SRT_TAKE:
            begin
                v_reg <= ent_rdata;
            end
            OP_SRT_SHIFT:
            begin
                j_reg <= j_reg - ADDR_W'(1);
            end
            OP_SRT_PLACE:
            begin
                i_reg <= i_reg + LEN_W'(1);
            end
            OP_RNK_INIT:
            begin
                i_reg   <= '0;
                top_reg <= '0;
            end
            OP_RNK_WR:
            begin
                top_reg  <= top_new;
                prev_reg <= {ent_rdata.r1, ent_rdata.r2};
                i_reg    <= i_reg + LEN_W'(1);
            end
            OP_DOUBLE:
            begin
                h_reg <= {h_reg[LEN_W-2:0], 1'b0};
                i_reg <= '0;
            end
            OP_LCP_INIT:
            begin
                i_reg <= '0;
            end
            OP_LCP_B:
            begin
                a_reg <= ent_rdata.idx;
            end
            OP_LCP_TAKE:
            begin
                b_reg <= ent_rdata.idx;
                c_reg <= '0;
            end
            OP_CMP_B:
            begin
                ta_reg <= text_rdata;
            end
            OP_CMP_INC:
            begin
                c_reg <= c_reg + LEN_W'(1);
            end
            OP_LCP_NEXT:
            begin
                if (c_reg > best_reg)
                begin
                    best_reg <= c_reg;
                end
                i_reg <= i_reg + LEN_W'(1);
            end
            OP_FINISH:
            begin
                // zero length means no repeat: report all ones
                res_item_reg.longest_len <= (best_reg == '0) ? '1 : OUT_W'(best_reg);
                res_item_reg.too_long    <= ovf_res_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

// ----- rtl/longest_k_repeat_suffix_array.sv -----
// Top level: longest substring repeated at least k times, via a prefix-doubling suffix array.
`timescale 1ns / 1ps
// Usage:
//   sym channel (sym_valid / sym_stall / sym_item) carries one text byte per transaction;
//   the transaction with last set closes the text and yields exactly one result on the
//   res channel (res_valid / res_stall / res_item). Bytes past MAX_LEN are dropped and
//   reported through too_long; a dropped last byte still closes the text.
//   cfg_we / cfg_data write k (min_repeats, reset 2, zero acts as one) while idle.
// Timing:
//   Loading takes one cycle per byte. After the last byte sym_stall stays high while
//   the text is processed. Each doubling round builds the rank-pair entries, sorts them
//   by insertion sort and re-ranks them; rounds run until all ranks differ (at most
//   log2 n + 1, with log2 rounded up). Each scan window compares text bytes until a
//   suffix end is reached or a byte mismatches. Each memory has one read port and one
//   write port, with registered read data.
// Reset: clears the controller, text length, overflow flag and result valid; memories
//   are not cleared, every entry whose read data is used is written before it is read.
// Stall: a pending result sits in the output register; new bytes are still taken, and
//   only the next result waits for res_stall to drop.
module longest_k_repeat_suffix_array import lkr_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           sym_valid,
    output logic           sym_stall,
    input  sym_t           sym_item,
    output logic           res_valid,
    input  logic           res_stall,
    output res_t           res_item,
    input  logic           cfg_we,
    input  logic [K_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    lkr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .sym_valid(sym_valid), .sym_last(sym_item.last), .sym_stall(sym_stall),
        .status(status), .cmd(cmd)
    );

    lkr_dp u_dp (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .status(status), .sym_item(sym_item),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
    );

endmodule
